@@ hw/rtl/rotation_matrix_to_quaternion_unit_defines.svh @@
// Assertion macros shared by the RTL.
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define RMQ_ASSERT(lbl, prop, clk, rstn) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define RMQ_ASSERT_NEXT(lbl, ante, cons, clk, rstn) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/rmq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;
  typedef enum logic [1:0] {
    CASE_W = 2'd0,
    CASE_X = 2'd1,
    CASE_Y = 2'd2,
    CASE_Z = 2'd3
  } case_e;
endpackage
`default_nettype wire

@@ hw/rtl/rmq_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none
// One pipelined step of a restoring square root (one result bit) or of a
// restoring divide (one quotient bit).
module rmq_stage #(
  parameter int unsigned RW = 24,
  parameter int unsigned DW = 24
) (
  input  wire logic          sqrt_i,
  input  wire logic [RW-1:0] rem_i,
  input  wire logic [DW-1:0] acc_i,
  input  wire logic [1:0]    bits_i,
  input  wire logic [DW-1:0] den_i,
  output logic      [RW-1:0] rem_o,
  output logic      [DW-1:0] acc_o
);
  logic [RW+1:0] shifted;
  logic [RW+1:0] trial;
  always_comb begin
    trial = '0;
    if (sqrt_i) begin
      shifted = {rem_i, bits_i};
      trial   = (RW+2)'({acc_i, 2'b01});
    end else begin
      shifted = (RW+2)'({rem_i, bits_i[0]});
      trial   = (RW+2)'(den_i);
    end
    if (shifted >= trial) begin
      rem_o = RW'(shifted - trial);
      acc_o = {acc_i[DW-2:0], 1'b1};
    end else begin
      rem_o = RW'(shifted);
      acc_o = {acc_i[DW-2:0], 1'b0};
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/rotation_matrix_to_quaternion_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "rotation_matrix_to_quaternion_unit_defines.svh"
// Rotation matrix to unit quaternion, four-case method, fully pipelined.
// Input channel: the nine matrix entries are taken when start_i is high
// and busy_o is low. busy_o is always low: a new beat may enter in every
// cycle. Output channel: valid_o marks the one cycle in which quat_*_o and
// case_used_o hold a result; the receiver cannot stall, so none is needed.
// From start_i to valid_o a beat passes the stage 1 and stage 2 registers,
// SQ square root steps (one result bit each, one register per step), DV
// divide steps (one quotient bit each) and the output register.
// Throughput is one matrix per clock; the three divides run as parallel
// lanes sharing four times the root as denominator. Reset clears only
// the valid bits of the pipeline, so no spurious result leaves the block
// after reset.
module rotation_matrix_to_quaternion_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic [FRAC_BITS+1:0] r00_i,
  input  wire logic [FRAC_BITS+1:0] r01_i,
  input  wire logic [FRAC_BITS+1:0] r02_i,
  input  wire logic [FRAC_BITS+1:0] r10_i,
  input  wire logic [FRAC_BITS+1:0] r11_i,
  input  wire logic [FRAC_BITS+1:0] r12_i,
  input  wire logic [FRAC_BITS+1:0] r20_i,
  input  wire logic [FRAC_BITS+1:0] r21_i,
  input  wire logic [FRAC_BITS+1:0] r22_i,
  output logic                      valid_o,
  output logic [FRAC_BITS+1:0]      quat_x_o,
  output logic [FRAC_BITS+1:0]      quat_y_o,
  output logic [FRAC_BITS+1:0]      quat_z_o,
  output logic [FRAC_BITS+1:0]      quat_w_o,
  output rmq_pkg::case_e            case_used_o
);
  import rmq_pkg::*;

  localparam int unsigned FW = FRAC_BITS + 2;
  // Root argument a fits in FW+2 bits signed; a*2^(F-2) up to AW bits.
  localparam int unsigned SW = FW + 3;
  localparam int unsigned AW = SW + FRAC_BITS - 2;
  localparam int unsigned SQ = (AW + 1) / 2;
  localparam int unsigned RW = SQ + 2;
  // Numerator magnitude fits NW bits; dividend is |n|<<F plus den/2.
  localparam int unsigned NW = FW + 1;
  localparam int unsigned DD = NW + FRAC_BITS + 1;
  localparam int unsigned QW = SQ + 2;
  localparam int unsigned DV = DD;
  localparam int unsigned DRW = QW + 1;
  localparam logic [FRAC_BITS+1:0] ONE = (FRAC_BITS+2)'(1) << FRAC_BITS;

  typedef logic signed [SW-1:0] sw_t;

  assign busy_o = 1'b0;

  // Stage 1: sign extend, diagonal sums and off-diagonal sums/differences.
  logic               v1_q;
  sw_t                tr_q, ax_q, ay_q, az_q;
  logic signed [FW:0] d21_q, d02_q, d10_q, s10_q, s02_q, s21_q;
  logic signed [FW-1:0] m00_q, m11_q, m22_q;

  function automatic sw_t sx(input logic [FW-1:0] v);
    return sw_t'(signed'(v));
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= start_i;
  end

  always_ff @(posedge clk_i) begin
    tr_q  <= sx(r00_i) + sx(r11_i) + sx(r22_i);
    ax_q  <= sx(ONE) + sx(r00_i) - sx(r11_i) - sx(r22_i);
    ay_q  <= sx(ONE) + sx(r11_i) - sx(r00_i) - sx(r22_i);
    az_q  <= sx(ONE) + sx(r22_i) - sx(r00_i) - sx(r11_i);
    m00_q <= signed'(r00_i);
    m11_q <= signed'(r11_i);
    m22_q <= signed'(r22_i);
    d21_q <= (FW+1)'(signed'(r21_i)) - (FW+1)'(signed'(r12_i));
    d02_q <= (FW+1)'(signed'(r02_i)) - (FW+1)'(signed'(r20_i));
    d10_q <= (FW+1)'(signed'(r10_i)) - (FW+1)'(signed'(r01_i));
    s10_q <= (FW+1)'(signed'(r10_i)) + (FW+1)'(signed'(r01_i));
    s02_q <= (FW+1)'(signed'(r02_i)) + (FW+1)'(signed'(r20_i));
    s21_q <= (FW+1)'(signed'(r21_i)) + (FW+1)'(signed'(r12_i));
  end

  // Stage 2: case selection, root argument and numerator routing, split into sign and magnitude.
  case_e        sel_d;
  sw_t          arg_d;
  logic signed [FW:0] n0_d, n1_d, n2_d;
  logic         v2_q;
  case_e        sel2_q;
  logic [AW-1:0] rad2_q;
  logic [2:0]   neg2_q;
  logic [NW-1:0] mag2_q [3];

  always_comb begin
    if (tr_q > 0) begin
      sel_d = CASE_W; arg_d = sx(ONE) + tr_q;
      n0_d = d21_q; n1_d = d02_q; n2_d = d10_q;
    end else if (m00_q > m11_q && m00_q > m22_q) begin
      sel_d = CASE_X; arg_d = ax_q;
      n0_d = d21_q; n1_d = s10_q; n2_d = s02_q;
    end else if (m11_q > m22_q) begin
      sel_d = CASE_Y; arg_d = ay_q;
      n0_d = d02_q; n1_d = s10_q; n2_d = s21_q;
    end else begin
      sel_d = CASE_Z; arg_d = az_q;
      n0_d = d10_q; n1_d = s02_q; n2_d = s21_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    sel2_q    <= sel_d;
    rad2_q    <= (arg_d > 0) ? (AW'(unsigned'(arg_d)) << (FRAC_BITS - 2)) : '0;
    neg2_q    <= {n2_d[FW], n1_d[FW], n0_d[FW]};
    mag2_q[0] <= n0_d[FW] ? NW'(-n0_d) : NW'(n0_d);
    mag2_q[1] <= n1_d[FW] ? NW'(-n1_d) : NW'(n1_d);
    mag2_q[2] <= n2_d[FW] ? NW'(-n2_d) : NW'(n2_d);
  end

  // Square root pipeline: one result bit per stage.
  localparam int unsigned RADW = 2 * SQ;
  logic          sv_q   [SQ+1];
  logic [RW-1:0] srem_q [SQ+1];
  logic [QW-1:0] sres_q [SQ+1];
  logic [RADW-1:0] srad_q [SQ+1];
  case_e         ssel_q [SQ+1];
  logic [2:0]    sneg_q [SQ+1];
  logic [NW-1:0] smag_q [SQ+1][3];

  always_comb begin
    sv_q[0]   = v2_q;
    srem_q[0] = '0;
    sres_q[0] = '0;
    srad_q[0] = RADW'(rad2_q);
    ssel_q[0] = sel2_q;
    sneg_q[0] = neg2_q;
    smag_q[0] = mag2_q;
  end

  for (genvar s = 0; s < SQ; s++) begin : g_sqrt
    logic [RW-1:0] rem_d;
    logic [QW-1:0] acc_d;
    rmq_stage #(.RW(RW), .DW(QW)) u_step (
      .sqrt_i (1'b1),
      .rem_i  (srem_q[s]),
      .acc_i  (sres_q[s]),
      .bits_i (srad_q[s][RADW-1 -: 2]),
      .den_i  ('0),
      .rem_o  (rem_d),
      .acc_o  (acc_d)
    );
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[s+1] <= 1'b0;
      else         sv_q[s+1] <= sv_q[s];
    end
    always_ff @(posedge clk_i) begin
      srem_q[s+1] <= rem_d;
      sres_q[s+1] <= acc_d;
      srad_q[s+1] <= srad_q[s] << 2;
      ssel_q[s+1] <= ssel_q[s];
      sneg_q[s+1] <= sneg_q[s];
      smag_q[s+1] <= smag_q[s];
    end
  end

  // Divide setup: den = 4q, dividend = (|n| << F) + den/2.
  logic [QW-1:0] root;
  logic [QW:0]   den_d;
  assign root  = sres_q[SQ];
  assign den_d = {root, 1'b0} << 1;

  logic          dv_q   [DV+1];
  logic [DRW-1:0] drem_q [DV+1][3];
  logic [DD-1:0]  dacc_q [DV+1][3];
  logic [DD-1:0]  dnum_q [DV+1][3];
  logic [DRW-1:0] dden_q [DV+1];
  logic [QW-1:0]  droot_q [DV+1];
  case_e          dsel_q [DV+1];
  logic [2:0]     dneg_q [DV+1];

  always_comb begin
    dv_q[0]    = sv_q[SQ];
    dden_q[0]  = DRW'(den_d);
    droot_q[0] = root;
    dsel_q[0]  = ssel_q[SQ];
    dneg_q[0]  = sneg_q[SQ];
    for (int l = 0; l < 3; l++) begin
      drem_q[0][l] = '0;
      dacc_q[0][l] = '0;
      dnum_q[0][l] = (DD'(smag_q[SQ][l]) << FRAC_BITS) + DD'(den_d >> 1);
    end
  end

  for (genvar s = 0; s < DV; s++) begin : g_div
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [DRW-1:0] rem_d;
      logic [DD-1:0]  acc_d;
      rmq_stage #(.RW(DRW), .DW(DD)) u_step (
        .sqrt_i (1'b0),
        .rem_i  (drem_q[s][l]),
        .acc_i  (dacc_q[s][l]),
        .bits_i ({1'b0, dnum_q[s][l][DD-1]}),
        .den_i  (DD'(dden_q[s])),
        .rem_o  (rem_d),
        .acc_o  (acc_d)
      );
      always_ff @(posedge clk_i) begin
        drem_q[s+1][l] <= rem_d;
        dacc_q[s+1][l] <= acc_d;
        dnum_q[s+1][l] <= dnum_q[s][l] << 1;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[s+1] <= 1'b0;
      else         dv_q[s+1] <= dv_q[s];
    end
    always_ff @(posedge clk_i) begin
      dden_q[s+1]  <= dden_q[s];
      droot_q[s+1] <= droot_q[s];
      dsel_q[s+1]  <= dsel_q[s];
      dneg_q[s+1]  <= dneg_q[s];
    end
  end

  // Output stage: saturate, restore sign, route components by case.
  logic [FW-1:0] comp_d [3];
  logic [FW-1:0] root_sat;
  logic          zero_den;
  assign zero_den = (droot_q[DV] == '0);
  assign root_sat = (droot_q[DV] > QW'(ONE)) ? ONE : FW'(droot_q[DV]);

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      logic [FW-1:0] mg;
      mg = (dacc_q[DV][l] > DD'(ONE)) ? ONE : FW'(dacc_q[DV][l]);
      if (zero_den) mg = '0;
      comp_d[l] = dneg_q[DV][l] ? FW'(-mg) : mg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else         valid_o <= dv_q[DV];
  end

  always_ff @(posedge clk_i) begin
    case_used_o <= dsel_q[DV];
    case (dsel_q[DV])
      CASE_W: begin
        quat_w_o <= root_sat; quat_x_o <= comp_d[0];
        quat_y_o <= comp_d[1]; quat_z_o <= comp_d[2];
      end
      CASE_X: begin
        quat_x_o <= root_sat; quat_w_o <= comp_d[0];
        quat_y_o <= comp_d[1]; quat_z_o <= comp_d[2];
      end
      CASE_Y: begin
        quat_y_o <= root_sat; quat_w_o <= comp_d[0];
        quat_x_o <= comp_d[1]; quat_z_o <= comp_d[2];
      end
      default: begin
        quat_z_o <= root_sat; quat_w_o <= comp_d[0];
        quat_x_o <= comp_d[1]; quat_y_o <= comp_d[2];
      end
    endcase
  end

  `RMQ_ASSERT(a_never_busy, !busy_o, clk_i, rst_ni)
  `RMQ_ASSERT_NEXT(a_stage1_tracks, start_i, v1_q, clk_i, rst_ni)
  `RMQ_ASSERT_NEXT(a_out_tracks, dv_q[DV], valid_o, clk_i, rst_ni)
  `RMQ_ASSERT_NEXT(a_no_spurious, !dv_q[DV], !valid_o, clk_i, rst_ni)
endmodule
`default_nettype wire

@@ tb/sv/rotation_matrix_to_quaternion_unit_tb.sv @@
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_unit_tb;
  import rmq_pkg::*;

  localparam int FB = 16;
  localparam int W = FB + 2;
  localparam longint ONE = 64'sd1 << FB;
  localparam int LATENCY = 57;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef logic [W-1:0] field_t;

  localparam field_t P1 = field_t'(ONE);
  localparam field_t N1 = field_t'(-ONE);
  localparam field_t Z0 = '0;
  localparam field_t PL = field_t'(1);
  localparam field_t NL = '1;
  localparam field_t HP = 18'h1ffff;
  localparam field_t HN = 18'h20000;

  typedef struct {
    field_t x;
    field_t y;
    field_t z;
    field_t w;
    case_e  sel;
  } quat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  field_t mat_q [9];
  logic busy_o;
  logic valid_o;
  field_t quat_x_o, quat_y_o, quat_z_o, quat_w_o;
  case_e case_used_o;
  int errors = 0;
  int idle_cycles = 0;

  always #1 clk_i = ~clk_i;

  initial begin
    for (int i = 0; i < 9; i++) mat_q[i] = '0;
  end

  rotation_matrix_to_quaternion_unit #(.FRAC_BITS(FB)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .r00_i(mat_q[0]), .r01_i(mat_q[1]), .r02_i(mat_q[2]),
    .r10_i(mat_q[3]), .r11_i(mat_q[4]), .r12_i(mat_q[5]),
    .r20_i(mat_q[6]), .r21_i(mat_q[7]), .r22_i(mat_q[8]),
    .valid_o(valid_o), .quat_x_o(quat_x_o), .quat_y_o(quat_y_o),
    .quat_z_o(quat_z_o), .quat_w_o(quat_w_o), .case_used_o(case_used_o)
  );

  function automatic longint sq_root_floor(longint v);
    longint r = 0;
    for (int b = 31; b >= 0; b--)
      if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= v) r += 64'sd1 << b;
    return r;
  endfunction

  function automatic longint scaled_quotient(longint n, longint q);
    longint mag, den, r;
    if (q <= 0) return 0;
    mag = (n < 0) ? -n : n;
    den = 4 * q;
    r = ((mag << FB) + (den >> 1)) / den;
    if (r > ONE) r = ONE;
    return (n < 0) ? -r : r;
  endfunction

  function automatic field_t clamp_unit(longint v);
    if (v > ONE) v = ONE;
    if (v < -ONE) v = -ONE;
    return field_t'(v);
  endfunction

  function automatic quat_t quat_of_matrix(field_t e [9]);
    longint m [9];
    longint tr, a, q, x, y, z, w;
    quat_t res;
    for (int i = 0; i < 9; i++) m[i] = longint'($signed(e[i]));
    tr = m[0] + m[4] + m[8];
    if (tr > 0) begin
      res.sel = CASE_W;
      a = ONE + tr;
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      res.sel = CASE_X;
      a = ONE + m[0] - m[4] - m[8];
    end else if (m[4] > m[8]) begin
      res.sel = CASE_Y;
      a = ONE + m[4] - m[0] - m[8];
    end else begin
      res.sel = CASE_Z;
      a = ONE + m[8] - m[0] - m[4];
    end
    q = (a <= 0) ? 0 : sq_root_floor(a << (FB - 2));
    case (res.sel)
      CASE_W: begin
        w = q;
        x = scaled_quotient(m[7] - m[5], q);
        y = scaled_quotient(m[2] - m[6], q);
        z = scaled_quotient(m[3] - m[1], q);
      end
      CASE_X: begin
        x = q;
        w = scaled_quotient(m[7] - m[5], q);
        y = scaled_quotient(m[3] + m[1], q);
        z = scaled_quotient(m[2] + m[6], q);
      end
      CASE_Y: begin
        y = q;
        w = scaled_quotient(m[2] - m[6], q);
        x = scaled_quotient(m[3] + m[1], q);
        z = scaled_quotient(m[7] + m[5], q);
      end
      default: begin
        z = q;
        w = scaled_quotient(m[3] - m[1], q);
        x = scaled_quotient(m[2] + m[6], q);
        y = scaled_quotient(m[7] + m[5], q);
      end
    endcase
    res.x = clamp_unit(x);
    res.y = clamp_unit(y);
    res.z = clamp_unit(z);
    res.w = clamp_unit(w);
    return res;
  endfunction

  class quat_scoreboard;
    quat_t pending [$];
    int fails = 0;

    function void note_matrix(field_t e [9]);
      pending.push_back(quat_of_matrix(e));
    endfunction

    function void check_quat(quat_t got);
      quat_t exp_q;
      if (pending.size() == 0) begin
        $error("unexpected result beat");
        fails++;
        return;
      end
      exp_q = pending.pop_front();
      if (got.x !== exp_q.x) begin
        $error("quat_x exp %0d got %0d", $signed(exp_q.x), $signed(got.x)); fails++;
      end
      if (got.y !== exp_q.y) begin
        $error("quat_y exp %0d got %0d", $signed(exp_q.y), $signed(got.y)); fails++;
      end
      if (got.z !== exp_q.z) begin
        $error("quat_z exp %0d got %0d", $signed(exp_q.z), $signed(got.z)); fails++;
      end
      if (got.w !== exp_q.w) begin
        $error("quat_w exp %0d got %0d", $signed(exp_q.w), $signed(got.w)); fails++;
      end
      if (got.sel !== exp_q.sel) begin
        $error("case_used exp %0d got %0d", exp_q.sel, got.sel); fails++;
      end
    endfunction
  endclass

  quat_scoreboard sb = new();

  // Inputs are sampled at the edge and the model sees the beat at once.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      quat_t got;
      if (start_i && !busy_o) begin
        sb.note_matrix(mat_q);
        idle_cycles <= 0;
      end else if (valid_o) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (valid_o) begin
        got.x = quat_x_o; got.y = quat_y_o; got.z = quat_z_o;
        got.w = quat_w_o; got.sel = case_used_o;
        sb.check_quat(got);
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("rotation_matrix_to_quaternion_unit regression: fail");
      $finish;
    end
  end

  function automatic field_t near_unit();
    case ($urandom_range(0, 5))
      0: return field_t'(ONE);
      1: return field_t'(-ONE);
      2: return field_t'(0);
      3: return field_t'($urandom);
      default: return field_t'($signed($urandom_range(0, 2 * ONE)) - ONE);
    endcase
  endfunction

  // A proper rotation built from a random unit quaternion, plus small noise.
  task automatic make_rotation(output field_t e [9]);
    real a, b, c, d, n;
    real r [9];
    a = $urandom_range(0, 2000) - 1000.0;
    b = $urandom_range(0, 2000) - 1000.0;
    c = $urandom_range(0, 2000) - 1000.0;
    d = $urandom_range(0, 2000) - 1000.0;
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n < 1.0) begin
      a = 1.0; n = 1.0;
    end
    a /= n; b /= n; c /= n; d /= n;
    r[0] = 1 - 2 * (c * c + d * d); r[1] = 2 * (b * c - a * d);
    r[2] = 2 * (b * d + a * c);     r[3] = 2 * (b * c + a * d);
    r[4] = 1 - 2 * (b * b + d * d); r[5] = 2 * (c * d - a * b);
    r[6] = 2 * (b * d - a * c);     r[7] = 2 * (c * d + a * b);
    r[8] = 1 - 2 * (b * b + c * c);
    for (int i = 0; i < 9; i++) begin
      longint v = longint'(r[i] * ONE) + $signed($urandom_range(0, 4)) - 2;
      e[i] = clamp_unit(v);
    end
  endtask

  task automatic send_matrix(field_t e [9], bit allow_gap);
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    for (int i = 0; i < 9; i++) mat_q[i] <= e[i];
    start_i <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  initial begin
    field_t e [9];
    field_t d [25][9];
    int nd;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Identity, half and quarter turns about each axis, sign extremes, degenerate inputs.
    d[0]  = '{P1, Z0, Z0, Z0, P1, Z0, Z0, Z0, P1};
    d[1]  = '{P1, Z0, Z0, Z0, N1, Z0, Z0, Z0, N1};
    d[2]  = '{N1, Z0, Z0, Z0, P1, Z0, Z0, Z0, N1};
    d[3]  = '{N1, Z0, Z0, Z0, N1, Z0, Z0, Z0, P1};
    d[4]  = '{Z0, N1, Z0, P1, Z0, Z0, Z0, Z0, P1};
    d[5]  = '{Z0, Z0, P1, Z0, P1, Z0, N1, Z0, Z0};
    d[6]  = '{P1, Z0, Z0, Z0, Z0, N1, Z0, P1, Z0};
    d[7]  = '{Z0, Z0, Z0, Z0, Z0, Z0, Z0, Z0, Z0};
    d[8]  = '{N1, Z0, Z0, Z0, N1, Z0, Z0, Z0, N1};
    d[9]  = '{N1, P1, P1, P1, N1, P1, P1, P1, N1};
    d[10] = '{P1, P1, P1, P1, P1, P1, P1, P1, P1};
    d[11] = '{P1, N1, P1, P1, N1, N1, N1, P1, N1};
    d[12] = '{Z0, P1, N1, N1, Z0, P1, P1, N1, Z0};
    // Raw bit extremes: single-LSB values and the largest positive and negative Q1.16 codes.
    d[13] = '{NL, NL, NL, NL, NL, NL, NL, NL, NL};
    d[14] = '{HP, HN, HP, HN, HN, HP, HN, HP, HN};
    d[15] = '{HN, HP, HN, HP, HP, HN, HP, HN, HP};
    d[16] = '{PL, Z0, Z0, Z0, Z0, Z0, Z0, Z0, NL};
    d[17] = '{Z0, Z0, Z0, Z0, PL, Z0, Z0, Z0, Z0};
    nd = 18;
    for (int k = 0; k < nd; k++) send_matrix(d[k], 1'b1);

    for (int k = 0; k < 1600; k++) begin
      if ($urandom_range(0, 9) < 7) make_rotation(e);
      else if ($urandom_range(0, 1)) for (int i = 0; i < 9; i++) e[i] = near_unit();
      else for (int i = 0; i < 9; i++) e[i] = field_t'($urandom);
      send_matrix(e, k < 1300);
    end
    start_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (sb.fails == 0 && errors == 0)
      $display("rotation_matrix_to_quaternion_unit regression: pass");
    else
      $display("rotation_matrix_to_quaternion_unit regression: fail");
    $finish;
  end
endmodule
